/* rtl/rotating_key_pcbc_byte_cipher_top_defines.svh */
// Assertion macros shared by the byte cipher RTL.
`ifndef ROTATING_KEY_PCBC_BYTE_CIPHER_TOP_DEFINES_SVH
`define ROTATING_KEY_PCBC_BYTE_CIPHER_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define RKPCBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RKPCBC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/rkpcbc_pkg.sv */
// Shared types, constants and helpers of the rotating key byte cipher.
package rkpcbc_pkg;

	localparam int KeyLen = 16;

	typedef logic [3:0] kidx_t;
	typedef logic [KeyLen-1:0][7:0] key_t;

	typedef enum logic [1:0] {
		PH_ADD_MIX,
		PH_XOR_MIX,
		PH_ROR_MIX,
		PH_ROT_MIX
	} phase_t;

	typedef enum logic [1:0] {
		CFG_DECRYPT_MODE,
		CFG_KEY_LOW,
		CFG_KEY_HIGH,
		CFG_INIT_CHAIN
	} cfg_reg_t;

	typedef struct packed {
		key_t       key;
		logic [7:0] chain;
		phase_t     phase;
	} cipher_state_t;

	localparam logic [63:0] KEY_LOW_RST  = 64'h0001_CE22_7C23_FEFF;
	localparam logic [63:0] KEY_HIGH_RST = 64'h0A5E_6DB2_1497_FFEA;
	localparam logic [7:0]  CHAIN_RST    = 8'h3D;

	// Source byte of each key position for the swap and group-rotate wirings.
	localparam kidx_t SWAP_SRC [KeyLen] = '{
		4'd3, 4'd2, 4'd0, 4'd1, 4'd6, 4'd4, 4'd7, 4'd5,
		4'd9, 4'd10, 4'd11, 4'd8, 4'd15, 4'd14, 4'd13, 4'd12
	};
	localparam kidx_t ROT_SRC [KeyLen] = '{
		4'd1, 4'd2, 4'd3, 4'd0, 4'd6, 4'd7, 4'd4, 4'd5,
		4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12
	};

	// Rotates by a constant amount between 1 and 31.
	function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned r);
		return (x >> r) | (x << (32 - r));
	endfunction

	function automatic logic [31:0] ext32(input logic [7:0] b);
		return {24'd0, b};
	endfunction

endpackage

/* rtl/rkpcbc_round.sv */
// One byte of the cipher: key wiring, phase mix, chain and key update.
module rkpcbc_round import rkpcbc_pkg::*; (
	input  cipher_state_t st_in,
	input  logic          decrypt,
	input  logic [7:0]    data_in,
	output logic [7:0]    data_out,
	output cipher_state_t st_out
);

	key_t        k1;
	key_t        k2;
	key_t        k3;
	logic [31:0] d32;
	logic [31:0] c32;
	logic [31:0] kk;
	logic [31:0] x;
	logic [7:0]  res;

	always_comb begin
		for (int i = 0; i < KeyLen; i++) begin
			k1[i] = st_in.key[SWAP_SRC[ROT_SRC[i]]];
		end

		d32 = ext32(data_in);
		c32 = ext32(st_in.chain);

		case (st_in.phase)
			PH_ADD_MIX: begin
				kk = ext32(k1[2]) ^ rol32(ext32(k1[3]), 3);
				if (decrypt) begin
					x = ((kk ^ d32) - ext32(k1[1])) ^ ext32(k1[0]);
				end else begin
					x = (((d32 ^ c32) ^ ext32(k1[0])) + ext32(k1[1])) ^ kk;
				end
			end
			PH_XOR_MIX: begin
				kk = ext32(k1[4]) ^ rol32(ext32(k1[5]), 2) ^ ext32(k1[6]) ^ ext32(k1[7]);
				x  = decrypt ? (d32 ^ kk) : (d32 ^ c32 ^ kk);
			end
			PH_ROR_MIX: begin
				kk = ext32(k1[13]) ^ ext32(k1[14]) ^ ext32(k1[15]);
				if (decrypt) begin
					x = (d32 ^ kk) - ror32(ext32(k1[12]), 3);
				end else begin
					x = ((d32 ^ c32) + ror32(ext32(k1[12]), 3)) ^ kk;
				end
			end
			default: begin
				// 32-bit wrap matters here: the final rotate pulls high bits down
				kk = rol32((rol32(ext32(k1[9]), 3) + ext32(k1[10]))
					- (ext32(k1[8]) ^ ror32(ext32(k1[11]), 5)), 7);
				x  = decrypt ? (d32 ^ kk) : (d32 ^ c32 ^ kk);
			end
		endcase

		res = decrypt ? (x[7:0] ^ st_in.chain) : x[7:0];

		for (int i = 0; i < KeyLen; i++) begin
			k2[i] = k1[ROT_SRC[i]];
		end
		k3     = k2;
		k3[0]  = k2[12];
		k3[5]  = k2[5] ^ k2[9];
		k3[10] = k2[10] ^ k2[2];
		k3[3]  = k2[3] ^ k2[15];

		data_out     = res;
		// cipher XOR plain is result XOR input in either direction
		st_out.key   = k3;
		st_out.chain = res ^ data_in;
		st_out.phase = phase_t'(st_in.phase + 2'd1);
	end

endmodule

/* rtl/rotating_key_pcbc_byte_cipher_top.sv */
// Top level of the rotating key PCBC byte cipher with its handshake and config registers.
// Byte stream cipher: each accepted beat carries one data byte and yields exactly one result
// byte, in order. The block takes one beat per clock cycle while the output is not stalled.
// A result passes through the input register and then the result register, which holds it
// while out_stall is high. The rate is set by the key/chain/phase update loop, which closes
// through the round logic between the input register and the result register. Set
// start_of_stream on the first byte of a stream to reload key, chain and phase from the config
// registers; key and chain writes take effect only at that point, the decrypt mode at every
// byte. Write config only while the block is idle.
module rotating_key_pcbc_byte_cipher_top import rkpcbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_stream,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  result_byte
);

	`include "rotating_key_pcbc_byte_cipher_top_defines.svh"

	// config registers
	logic          decrypt_q;
	logic [63:0]   key_low_q;
	logic [63:0]   key_high_q;
	logic [7:0]    chain_init_q;

	// input stage
	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          start_s1;

	// running cipher state and result register
	cipher_state_t state_q;
	logic          out_valid_q;
	logic [7:0]    result_q;

	cipher_state_t st_base;
	cipher_state_t st_next;
	logic [7:0]    round_res;
	logic          adv;
	logic          in_acc;

	// Advance the input stage into the result register when that register is free or drains.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// Reload from config at the start of a stream, else continue from the running state.
	always_comb begin
		if (start_s1) begin
			st_base.key   = {key_high_q, key_low_q};
			st_base.chain = chain_init_q;
			st_base.phase = PH_ADD_MIX;
		end else begin
			st_base = state_q;
		end
	end

	rkpcbc_round u_round (
		.st_in    (st_base),
		.decrypt  (decrypt_q),
		.data_in  (data_s1),
		.data_out (round_res),
		.st_out   (st_next)
	);

	// Config writes; every value of the index selects one of the four registers in the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q    <= 1'b0;
			key_low_q    <= KEY_LOW_RST;
			key_high_q   <= KEY_HIGH_RST;
			chain_init_q <= CHAIN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DECRYPT_MODE: decrypt_q    <= cfg_data[0];
				CFG_KEY_LOW:      key_low_q    <= cfg_data;
				CFG_KEY_HIGH:     key_high_q   <= cfg_data;
				CFG_INIT_CHAIN:   chain_init_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input stage: capture a beat, drop the valid once it moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1  <= data_byte;
			start_s1 <= start_of_stream;
		end
	end

	// Cipher state advances exactly once per byte that reaches the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.key   <= {KEY_HIGH_RST, KEY_LOW_RST};
			state_q.chain <= CHAIN_RST;
			state_q.phase <= PH_ADD_MIX;
		end else if (adv) begin
			state_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= round_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_byte = result_q;

	`RKPCBC_ASSERT_SAME(a_stall_needs_item, in_stall, valid_s1, "stall without a held byte")
	`RKPCBC_ASSERT_NEXT(a_adv_gives_result, adv, out_valid_q, "advanced byte lost")
	`RKPCBC_ASSERT_NEXT(a_idle_state_holds, !adv, $stable(state_q), "state moved without a byte")
	`RKPCBC_ASSERT_NEXT(a_phase_steps, adv && !start_s1,
		state_q.phase == phase_t'($past(state_q.phase) + 2'd1), "phase did not step")
	`RKPCBC_ASSERT_NEXT(a_start_phase, adv && start_s1,
		state_q.phase == PH_XOR_MIX, "phase not restarted at stream start")

endmodule
